// ===== rtl/ssfs_pkg.sv =====
`timescale 1ns / 1ps

package ssfs_pkg;

   // Configuration port geometry
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 12;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FRAMES_PER_ROW = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_COUNT    = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH    = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT   = 4'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X       = 4'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y       = 4'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_LOOP_LIMIT     = 4'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_END_MODE       = 4'd7;

   // Item actions
   localparam logic ACTION_TICK    = 1'b0;
   localparam logic ACTION_RESTART = 1'b1;

   // end_mode bits
   localparam int END_MODE_REWIND = 0;
   localparam int END_MODE_KEEP   = 1;

   // Field widths
   localparam int COUNT_W = 11;
   localparam int PIX_W   = 12;
   localparam int FRAME_W = 12;
   localparam int COORD_W = 16;
   localparam int PROD_W  = 24;
   localparam int SUM_W   = 26;

   // One quotient bit per divider cycle
   localparam int DIV_STEPS = FRAME_W;

   // Clamp a signed sum to the coordinate range
   function automatic logic [COORD_W-1:0] sat16(input logic signed [SUM_W-1:0] v);
      logic [COORD_W-1:0] r;
      if (v < 0) begin
         r = '0;
      end else if (v > $signed(SUM_W'(65535))) begin
         r = '1;
      end else begin
         r = v[COORD_W-1:0];
      end
      return r;
   endfunction

endpackage

// ===== rtl/sprite_sheet_frame_sequencer_core.sv =====
`timescale 1ns / 1ps

// Channel  | Direction | Handshake           | Payload
// ---------+-----------+---------------------+----------------------------------------
// req_     | in        | req_valid/req_stall | action, now_ms, delay_ms, play_reverse,
//          |           |                     | shown
// rsp_     | out       | rsp_valid/rsp_stall | clip_left/top/right/bottom, clip_written,
//          |           |                     | finished
// csr_     | in        | csr_valid/csr_ready | index, wdata (always ready)
//
// An item that moves to a new frame passes the transfer step, the shared restoring divider
// (one quotient bit each step), then a multiply on the shared 12x12 multiplier and an add,
// first for x and then for y, and a last step to load the result register. Items that change
// no frame go from the transfer to the load. The input is stalled while an item is at work.
// The result register frees the sequencer: a new item may start while a result waits.
// Reset is synchronous and restores register defaults and the sequencer state.

module sprite_sheet_frame_sequencer_core (
   input  logic                                 clock,
   input  logic                                 reset,
   // input items
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_action,
   input  logic [31:0]                          req_now_ms,
   input  logic [15:0]                          req_delay_ms,
   input  logic                                 req_play_reverse,
   input  logic                                 req_shown,
   // results
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [15:0]                          rsp_clip_left,
   output logic [15:0]                          rsp_clip_top,
   output logic [15:0]                          rsp_clip_right,
   output logic [15:0]                          rsp_clip_bottom,
   output logic                                 rsp_clip_written,
   output logic                                 rsp_finished,
   // configuration writes
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [ssfs_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ssfs_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   import ssfs_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_MULX,
      ST_ADDX,
      ST_MULY,
      ST_ADDY,
      ST_FINISH
   } state_type;

   // configuration registers
   logic [COUNT_W-1:0] fpr_ff, fpr_in;
   logic [COUNT_W-1:0] fcnt_ff, fcnt_in;
   logic [PIX_W-1:0]   fw_ff, fw_in;
   logic [PIX_W-1:0]   fh_ff, fh_in;
   logic [PIX_W-1:0]   ox_ff, ox_in;
   logic [PIX_W-1:0]   oy_ff, oy_in;
   logic [7:0]         loop_lim_ff, loop_lim_in;
   logic [1:0]         end_mode_ff, end_mode_in;

   // animation state
   logic signed [FRAME_W-1:0] frame_ff, frame_in;
   logic [31:0]               last_time_ff, last_time_in;
   logic [7:0]                loops_ff, loops_in;
   logic                      done_ff, done_in;
   logic                      going_back_ff, going_back_in;
   logic [COORD_W-1:0]        left_ff, left_in;
   logic [COORD_W-1:0]        top_ff, top_in;
   logic [COORD_W-1:0]        right_ff, right_in;
   logic [COORD_W-1:0]        bottom_ff, bottom_in;

   // sequencer and shared datapath
   state_type          state_ff, state_in;
   logic [3:0]         cnt_ff, cnt_in;
   logic [COUNT_W-1:0] rem_ff, rem_in;
   logic [FRAME_W-1:0] quo_ff, quo_in;
   logic               neg_ff, neg_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic               written_ff, written_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [COORD_W-1:0] rsp_left_ff, rsp_left_in;
   logic [COORD_W-1:0] rsp_top_ff, rsp_top_in;
   logic [COORD_W-1:0] rsp_right_ff, rsp_right_in;
   logic [COORD_W-1:0] rsp_bottom_ff, rsp_bottom_in;
   logic               rsp_written_ff, rsp_written_in;
   logic               rsp_finished_ff, rsp_finished_in;

   // combinational helpers
   logic                      req_take;
   logic [COUNT_W-1:0]        cols;
   logic [COUNT_W-1:0]        last_idx;
   logic signed [FRAME_W:0]   frame_ext;
   logic signed [FRAME_W:0]   last_ext;
   logic                      past_last;
   logic                      limit_hit;
   logic                      step_due;
   logic [31:0]               elapsed;
   logic                      show_go;
   logic signed [FRAME_W-1:0] show_f;
   logic signed [FRAME_W-1:0] rev_f;
   logic                      rev_back;
   logic [FRAME_W-1:0]        div_trial;
   logic                      div_ge;
   logic [FRAME_W-1:0]        mul_a;
   logic [PIX_W-1:0]          mul_b;
   logic [PROD_W-1:0]         mul_p;
   logic [PIX_W:0]            base_lo;
   logic [PIX_W:0]            base_hi;
   logic signed [SUM_W-1:0]   prod_s;
   logic signed [SUM_W-1:0]   sum_lo;
   logic signed [SUM_W-1:0]   sum_hi;

   assign req_take  = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   // zero columns or frames count as one
   assign cols      = (fpr_ff == '0) ? COUNT_W'(1) : fpr_ff;
   assign last_idx  = (fcnt_ff == '0) ? '0 : fcnt_ff - COUNT_W'(1);
   assign frame_ext = {frame_ff[FRAME_W-1], frame_ff};
   assign last_ext  = $signed({2'b00, last_idx});
   assign past_last = frame_ext > last_ext;
   assign limit_hit = (loop_lim_ff != '0) && (loops_ff == loop_lim_ff);
   assign elapsed   = req_now_ms - last_time_ff;
   assign step_due  = elapsed >= {16'd0, req_delay_ms};

   // divider step: shift in the next dividend bit, subtract if it fits
   assign div_trial = {rem_ff, quo_ff[FRAME_W-1]};
   assign div_ge    = div_trial >= {1'b0, cols};

   // shared multiplier: column by width, then row by height
   assign mul_a = (state_ff == ST_MULX) ? {1'b0, rem_ff} : quo_ff;
   assign mul_b = (state_ff == ST_MULX) ? fw_ff : fh_ff;
   assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

   // shared adder pair: origin edge and far edge, offset by the product
   assign base_lo = (state_ff == ST_ADDX) ? {1'b0, ox_ff} : {1'b0, oy_ff};
   assign base_hi = (state_ff == ST_ADDX) ? ({1'b0, ox_ff} + {1'b0, fw_ff})
                                          : ({1'b0, oy_ff} + {1'b0, fh_ff});
   assign prod_s  = $signed({2'b00, prod_ff});
   assign sum_lo  = neg_ff ? ($signed(SUM_W'(base_lo)) - prod_s)
                           : ($signed(SUM_W'(base_lo)) + prod_s);
   assign sum_hi  = neg_ff ? ($signed(SUM_W'(base_hi)) - prod_s)
                           : ($signed(SUM_W'(base_hi)) + prod_s);

   // reverse play: bounce off the top, restart climbing from below zero
   always_comb begin
      rev_f    = frame_ff;
      rev_back = going_back_ff;
      if (past_last) begin
         rev_f    = $signed({1'b0, last_idx} - FRAME_W'(1));
         rev_back = 1'b1;
      end else if (frame_ff < 0) begin
         rev_f    = FRAME_W'(1);
         rev_back = 1'b0;
      end
   end

   // next-state logic
   always_comb begin
      fpr_in          = fpr_ff;
      fcnt_in         = fcnt_ff;
      fw_in           = fw_ff;
      fh_in           = fh_ff;
      ox_in           = ox_ff;
      oy_in           = oy_ff;
      loop_lim_in     = loop_lim_ff;
      end_mode_in     = end_mode_ff;
      frame_in        = frame_ff;
      last_time_in    = last_time_ff;
      loops_in        = loops_ff;
      done_in         = done_ff;
      going_back_in   = going_back_ff;
      left_in         = left_ff;
      top_in          = top_ff;
      right_in        = right_ff;
      bottom_in       = bottom_ff;
      state_in        = state_ff;
      cnt_in          = cnt_ff;
      rem_in          = rem_ff;
      quo_in          = quo_ff;
      neg_in          = neg_ff;
      prod_in         = prod_ff;
      written_in      = written_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_left_in     = rsp_left_ff;
      rsp_top_in      = rsp_top_ff;
      rsp_right_in    = rsp_right_ff;
      rsp_bottom_in   = rsp_bottom_ff;
      rsp_written_in  = rsp_written_ff;
      rsp_finished_in = rsp_finished_ff;
      show_go         = 1'b0;
      show_f          = '0;

      // register writes
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FRAMES_PER_ROW: fpr_in      = csr_wdata[COUNT_W-1:0];
            CSR_FRAME_COUNT:    fcnt_in     = csr_wdata[COUNT_W-1:0];
            CSR_FRAME_WIDTH:    fw_in       = csr_wdata[PIX_W-1:0];
            CSR_FRAME_HEIGHT:   fh_in       = csr_wdata[PIX_W-1:0];
            CSR_ORIGIN_X:       ox_in       = csr_wdata[PIX_W-1:0];
            CSR_ORIGIN_Y:       oy_in       = csr_wdata[PIX_W-1:0];
            CSR_LOOP_LIMIT:     loop_lim_in = csr_wdata[7:0];
            CSR_END_MODE:       end_mode_in = csr_wdata[1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in   = ST_FINISH;
               written_in = 1'b0;
               if (req_action == ACTION_RESTART) begin
                  frame_in      = '0;
                  last_time_in  = '0;
                  loops_in      = '0;
                  done_in       = 1'b0;
                  going_back_in = 1'b0;
                  show_go       = 1'b1;
               end else if (req_shown) begin
                  if (done_ff) begin
                     written_in = end_mode_ff[END_MODE_KEEP];
                  end else if (!step_due) begin
                     written_in = 1'b1;
                  end else begin
                     written_in   = 1'b1;
                     last_time_in = req_now_ms;
                     if (limit_hit) begin
                        // loop limit reached: finish, and rewind if end_mode asks and play is forward
                        done_in = 1'b1;
                        show_go = !req_play_reverse && end_mode_ff[END_MODE_REWIND];
                     end else if (req_play_reverse) begin
                        if (past_last) begin
                           loops_in = loops_ff + 8'd1;
                        end
                        going_back_in = rev_back;
                        show_go       = 1'b1;
                        show_f        = rev_f;
                        frame_in      = rev_back ? rev_f - FRAME_W'(1)
                                                 : rev_f + FRAME_W'(1);
                     end else if (past_last) begin
                        loops_in = loops_ff + 8'd1;
                        frame_in = FRAME_W'(1);
                        show_go  = 1'b1;
                     end else begin
                        show_go  = 1'b1;
                        show_f   = frame_ff;
                        frame_in = frame_ff + FRAME_W'(1);
                     end
                  end
               end
               // start the divider on the frame magnitude
               if (show_go) begin
                  state_in = ST_DIV;
                  neg_in   = show_f[FRAME_W-1];
                  quo_in   = show_f[FRAME_W-1] ? FRAME_W'(-show_f) : show_f;
                  rem_in   = '0;
                  cnt_in   = '0;
               end
            end
         end

         ST_DIV: begin
            rem_in = div_ge ? COUNT_W'(div_trial - {1'b0, cols}) : div_trial[COUNT_W-1:0];
            quo_in = {quo_ff[FRAME_W-2:0], div_ge};
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'(DIV_STEPS - 1)) begin
               state_in = ST_MULX;
            end
         end

         ST_MULX: begin
            prod_in  = mul_p;
            state_in = ST_ADDX;
         end

         ST_ADDX: begin
            left_in  = sat16(sum_lo);
            right_in = sat16(sum_hi);
            state_in = ST_MULY;
         end

         ST_MULY: begin
            prod_in  = mul_p;
            state_in = ST_ADDY;
         end

         ST_ADDY: begin
            top_in    = sat16(sum_lo);
            bottom_in = sat16(sum_hi);
            state_in  = ST_FINISH;
         end

         ST_FINISH: begin
            // load the result register once it is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in    = 1'b1;
               rsp_left_in     = left_ff;
               rsp_top_in      = top_ff;
               rsp_right_in    = right_ff;
               rsp_bottom_in   = bottom_ff;
               rsp_written_in  = written_ff;
               rsp_finished_in = done_ff;
               state_in        = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fpr_ff        <= COUNT_W'(1);
         fcnt_ff       <= COUNT_W'(1);
         fw_ff         <= '0;
         fh_ff         <= '0;
         ox_ff         <= '0;
         oy_ff         <= '0;
         loop_lim_ff   <= '0;
         end_mode_ff   <= '0;
         frame_ff      <= '0;
         last_time_ff  <= '0;
         loops_ff      <= '0;
         done_ff       <= 1'b0;
         going_back_ff <= 1'b0;
         left_ff       <= '0;
         top_ff        <= '0;
         right_ff      <= '0;
         bottom_ff     <= '0;
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
      end else begin
         fpr_ff        <= fpr_in;
         fcnt_ff       <= fcnt_in;
         fw_ff         <= fw_in;
         fh_ff         <= fh_in;
         ox_ff         <= ox_in;
         oy_ff         <= oy_in;
         loop_lim_ff   <= loop_lim_in;
         end_mode_ff   <= end_mode_in;
         frame_ff      <= frame_in;
         last_time_ff  <= last_time_in;
         loops_ff      <= loops_in;
         done_ff       <= done_in;
         going_back_ff <= going_back_in;
         left_ff       <= left_in;
         top_ff        <= top_in;
         right_ff      <= right_in;
         bottom_ff     <= bottom_in;
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      cnt_ff          <= cnt_in;
      rem_ff          <= rem_in;
      quo_ff          <= quo_in;
      neg_ff          <= neg_in;
      prod_ff         <= prod_in;
      written_ff      <= written_in;
      rsp_left_ff     <= rsp_left_in;
      rsp_top_ff      <= rsp_top_in;
      rsp_right_ff    <= rsp_right_in;
      rsp_bottom_ff   <= rsp_bottom_in;
      rsp_written_ff  <= rsp_written_in;
      rsp_finished_ff <= rsp_finished_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_clip_left    = rsp_left_ff;
   assign rsp_clip_top     = rsp_top_ff;
   assign rsp_clip_right   = rsp_right_ff;
   assign rsp_clip_bottom  = rsp_bottom_ff;
   assign rsp_clip_written = rsp_written_ff;
   assign rsp_finished     = rsp_finished_ff;

   // a restart clears the sequence
   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      req_take && req_action == ACTION_RESTART |=>
         !done_ff && frame_ff == '0 && loops_ff == '0)
      else $error("restart did not clear the sequencer");

   // partial remainder stays below the divisor
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> rem_ff < cols)
      else $error("divider remainder out of range");

   // far edges never lie before near edges
   a_rect_order: assert property (@(posedge clock) disable iff (reset)
      left_ff <= right_ff && top_ff <= bottom_ff)
      else $error("clip rectangle inverted");

   // a result appears only from the final sequencer step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result raised outside the final step");

endmodule

// ===== test/sprite_sheet_frame_sequencer_core_tb.sv =====
`timescale 1ns / 1ps

module sprite_sheet_frame_sequencer_core_tb;
   import ssfs_pkg::*;

   // One tick or restart as it crosses the input channel
   typedef struct packed {
      logic        action;
      logic [31:0] now_ms;
      logic [15:0] delay_ms;
      logic        play_reverse;
      logic        shown;
   } tick_type;

   // One clip rectangle report as it leaves the result channel
   typedef struct packed {
      logic [15:0] left;
      logic [15:0] top;
      logic [15:0] right;
      logic [15:0] bottom;
      logic        written;
      logic        finished;
   } clip_type;

   // Tracks the animation state and holds the clips still owed by the block
   class clip_tracker_type;
      bit [10:0] cols_cfg, count_cfg;
      bit [11:0] width_cfg, height_cfg, ox_cfg, oy_cfg;
      bit [7:0]  limit_cfg;
      bit [1:0]  mode_cfg;

      int        frame_no;
      bit [31:0] last_ms;
      bit [7:0]  loops;
      bit        anim_done;
      bit        backward;
      bit [15:0] rect [4];

      clip_type  expected_clips [$];
      int        ticks, restarts, steps, finishes, checked, errors;

      function new();
         cols_cfg   = 11'd1;
         count_cfg  = 11'd1;
         width_cfg  = '0;
         height_cfg = '0;
         ox_cfg     = '0;
         oy_cfg     = '0;
         limit_cfg  = '0;
         mode_cfg   = '0;
         frame_no   = 0;
         last_ms    = '0;
         loops      = '0;
         anim_done  = 1'b0;
         backward   = 1'b0;
         foreach (rect[i]) rect[i] = '0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_FRAMES_PER_ROW: cols_cfg   = data[10:0];
            CSR_FRAME_COUNT:    count_cfg  = data[10:0];
            CSR_FRAME_WIDTH:    width_cfg  = data;
            CSR_FRAME_HEIGHT:   height_cfg = data;
            CSR_ORIGIN_X:       ox_cfg     = data;
            CSR_ORIGIN_Y:       oy_cfg     = data;
            CSR_LOOP_LIMIT:     limit_cfg  = data[7:0];
            CSR_END_MODE:       mode_cfg   = data[1:0];
            default: ;
         endcase
      endfunction

      function bit [15:0] clamp16(longint v);
         if (v < 0) return 16'd0;
         if (v > 65535) return 16'hFFFF;
         return v[15:0];
      endfunction

      // Frame number lives in a 12-bit two's complement register
      function int wrap12(int v);
         logic signed [11:0] s;
         s = v[11:0];
         return int'(s);
      endfunction

      function int last_index();
         return (count_cfg == 0) ? 0 : int'(count_cfg) - 1;
      endfunction

      function bit limit_hit();
         return limit_cfg != 0 && loops == limit_cfg;
      endfunction

      function void show_origin();
         rect[0] = 16'(ox_cfg);
         rect[1] = 16'(oy_cfg);
         rect[2] = clamp16(longint'(ox_cfg) + longint'(width_cfg));
         rect[3] = clamp16(longint'(oy_cfg) + longint'(height_cfg));
      endfunction

      // Grid cell by truncating division; negative frames give negative cells
      function void show_frame(int f);
         int     cols, mag, col, row;
         longint dx, dy;
         cols = (cols_cfg == 0) ? 1 : int'(cols_cfg);
         mag  = (f < 0) ? -f : f;
         col  = mag % cols;
         row  = mag / cols;
         if (f < 0) begin
            col = -col;
            row = -row;
         end
         dx = longint'(col) * longint'(width_cfg);
         dy = longint'(row) * longint'(height_cfg);
         rect[0] = clamp16(longint'(ox_cfg) + dx);
         rect[1] = clamp16(longint'(oy_cfg) + dy);
         rect[2] = clamp16(longint'(ox_cfg) + longint'(width_cfg) + dx);
         rect[3] = clamp16(longint'(oy_cfg) + longint'(height_cfg) + dy);
      endfunction

      function void step_forward();
         if (limit_hit()) begin
            anim_done = 1'b1;
            finishes++;
            if (mode_cfg[END_MODE_REWIND]) show_origin();
         end else if (frame_no > last_index()) begin
            show_origin();
            loops++;
            frame_no = 1;
         end else begin
            show_frame(frame_no);
            frame_no = wrap12(frame_no + 1);
         end
      endfunction

      // Ping-pong: turn round past the top, turn again below zero
      function void step_reverse();
         int last;
         last = last_index();
         if (limit_hit()) begin
            anim_done = 1'b1;
            finishes++;
         end else begin
            if (frame_no > last) begin
               loops++;
               frame_no = last - 1;
               backward = 1'b1;
            end else if (frame_no < 0) begin
               frame_no = 1;
               backward = 1'b0;
            end
            show_frame(frame_no);
            frame_no = wrap12(backward ? frame_no - 1 : frame_no + 1);
         end
      endfunction

      function void note_tick(tick_type t);
         clip_type  want;
         bit        written;
         bit [31:0] elapsed;
         written = 1'b0;
         ticks++;
         if (t.action == ACTION_RESTART) begin
            restarts++;
            frame_no  = 0;
            last_ms   = '0;
            loops     = '0;
            anim_done = 1'b0;
            backward  = 1'b0;
            show_origin();
         end else if (t.shown) begin
            elapsed = t.now_ms - last_ms;
            if (anim_done) begin
               written = mode_cfg[END_MODE_KEEP];
            end else if (elapsed < {16'd0, t.delay_ms}) begin
               written = 1'b1;
            end else begin
               last_ms = t.now_ms;
               steps++;
               if (t.play_reverse) step_reverse();
               else step_forward();
               written = 1'b1;
            end
         end
         want.left     = rect[0];
         want.top      = rect[1];
         want.right    = rect[2];
         want.bottom   = rect[3];
         want.written  = written;
         want.finished = anim_done;
         expected_clips.push_back(want);
      endfunction

      function void compare_field(string name, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         end
      endfunction

      function void check_clip(clip_type got);
         clip_type want;
         if (expected_clips.size() == 0) begin
            errors++;
            $display("%0t: clip with nothing expected, got %h", $time, got);
         end else begin
            want = expected_clips.pop_front();
            checked++;
            compare_field("clip_left", want.left, got.left);
            compare_field("clip_top", want.top, got.top);
            compare_field("clip_right", want.right, got.right);
            compare_field("clip_bottom", want.bottom, got.bottom);
            compare_field("clip_written", 16'(want.written), 16'(got.written));
            compare_field("finished", 16'(want.finished), 16'(got.finished));
         end
      endfunction
   endclass

   logic                  clock            = 1'b0;
   logic                  reset            = 1'b1;
   logic                  req_valid        = 1'b0;
   logic                  req_stall;
   logic                  req_action       = 1'b0;
   logic [31:0]           req_now_ms       = '0;
   logic [15:0]           req_delay_ms     = '0;
   logic                  req_play_reverse = 1'b0;
   logic                  req_shown        = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall        = 1'b0;
   logic [15:0]           rsp_clip_left;
   logic [15:0]           rsp_clip_top;
   logic [15:0]           rsp_clip_right;
   logic [15:0]           rsp_clip_bottom;
   logic                  rsp_clip_written;
   logic                  rsp_finished;
   logic                  csr_valid        = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index        = '0;
   logic [CSR_DATA_W-1:0] csr_wdata        = '0;

   clip_tracker_type clips = new();

   // Stimulus knobs, changed per phase
   int          send_idle_pct  = 0;
   int          stall_pct      = 0;
   int          reverse_pct    = 50;
   int          hold_left      = 0;
   bit          steady_forward = 1'b0;
   logic [31:0] sim_ms         = '0;

   sprite_sheet_frame_sequencer_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_now_ms       (req_now_ms),
      .req_delay_ms     (req_delay_ms),
      .req_play_reverse (req_play_reverse),
      .req_shown        (req_shown),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_clip_left    (rsp_clip_left),
      .rsp_clip_top     (rsp_clip_top),
      .rsp_clip_right   (rsp_clip_right),
      .rsp_clip_bottom  (rsp_clip_bottom),
      .rsp_clip_written (rsp_clip_written),
      .rsp_finished     (rsp_finished),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // 100 MHz clock
   always begin
      #5;
      clock = 1'b1;
      #5;
      clock = 1'b0;
   end

   // Result side: check each transfer, then choose the next stall
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         clips.check_clip({rsp_clip_left, rsp_clip_top, rsp_clip_right, rsp_clip_bottom,
                           rsp_clip_written, rsp_finished});
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Watchdog
   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      clips.write_reg(idx, data);
   endtask

   task automatic apply_settings(logic [11:0] cols, logic [11:0] count, logic [11:0] w,
                                 logic [11:0] h, logic [11:0] ox, logic [11:0] oy,
                                 logic [11:0] limit, logic [11:0] mode);
      csr_write(CSR_FRAMES_PER_ROW, cols);
      csr_write(CSR_FRAME_COUNT, count);
      csr_write(CSR_FRAME_WIDTH, w);
      csr_write(CSR_FRAME_HEIGHT, h);
      csr_write(CSR_ORIGIN_X, ox);
      csr_write(CSR_ORIGIN_Y, oy);
      csr_write(CSR_LOOP_LIMIT, limit);
      csr_write(CSR_END_MODE, mode);
      csr_valid <= 1'b0;
   endtask

   // Random sheet geometry, biased to small counts so loops finish
   task automatic pick_settings();
      logic [11:0] cols, count, w, h, ox, oy, limit;
      case ($urandom_range(5))
         0:       cols = 12'd1;
         1:       cols = 12'd0;
         2:       cols = 12'd1024;
         3:       cols = 12'd2047;
         default: cols = 12'($urandom_range(2, 8));
      endcase
      case ($urandom_range(5))
         0:       count = 12'd1;
         1:       count = 12'd0;
         2:       count = 12'd1024;
         default: count = 12'($urandom_range(2, 9));
      endcase
      case ($urandom_range(3))
         0:       w = 12'd0;
         1:       w = 12'd4095;
         default: w = 12'($urandom_range(1, 400));
      endcase
      case ($urandom_range(3))
         0:       h = 12'd0;
         1:       h = 12'd4095;
         default: h = 12'($urandom_range(1, 400));
      endcase
      ox = 12'($urandom_range(0, 4095));
      oy = 12'($urandom_range(0, 4095));
      case ($urandom_range(4))
         0:       limit = 12'd0;
         1:       limit = 12'd255;
         default: limit = 12'($urandom_range(1, 3));
      endcase
      apply_settings(cols, count, w, h, ox, oy, limit, 12'($urandom_range(0, 3)));
   endtask

   function automatic tick_type random_tick();
      tick_type t;
      t.action       = ($urandom_range(99) < 4) ? ACTION_RESTART : ACTION_TICK;
      t.shown        = ($urandom_range(99) >= 8);
      t.play_reverse = ($urandom_range(99) < reverse_pct);
      sim_ms         = sim_ms + $urandom_range(0, 24);
      t.now_ms       = sim_ms;
      case ($urandom_range(9))
         0: begin
            t.now_ms   = $urandom();
            t.delay_ms = 16'($urandom());
         end
         1:       t.delay_ms = 16'hFFFF;
         2:       t.delay_ms = '0;
         default: t.delay_ms = 16'($urandom_range(0, 20));
      endcase
      // long loop-count runs: one step per item, nothing to interrupt them
      if (steady_forward) begin
         t.action       = ACTION_TICK;
         t.shown        = 1'b1;
         t.play_reverse = 1'b0;
         t.now_ms       = sim_ms;
         t.delay_ms     = '0;
      end
      return t;
   endfunction

   // Offer one item, with an optional idle gap first, and wait for its transfer
   task automatic send_tick(tick_type t);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid        <= 1'b1;
      req_action       <= t.action;
      req_now_ms       <= t.now_ms;
      req_delay_ms     <= t.delay_ms;
      req_play_reverse <= t.play_reverse;
      req_shown        <= t.shown;
      do @(posedge clock); while (req_stall !== 1'b0);
      clips.note_tick(t);
   endtask

   task automatic wait_drained();
      do @(posedge clock); while (clips.expected_clips.size() != 0);
   endtask

   initial begin
      int p, k, n;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: forward play to a rewound finish, then reverse to a plain finish
      apply_settings(12'd3, 12'd5, 12'd100, 12'd50, 12'd7, 12'd9, 12'd1, 12'd1);
      send_tick({ACTION_RESTART, 32'd0, 16'd0, 1'b0, 1'b0});
      send_tick({ACTION_TICK, 32'd100, 16'd0, 1'b0, 1'b0});
      send_tick({ACTION_TICK, 32'd5, 16'd10, 1'b0, 1'b1});
      for (k = 1; k <= 8; k++) send_tick({ACTION_TICK, 32'(10 * k), 16'd0, 1'b0, 1'b1});
      send_tick({ACTION_RESTART, 32'd0, 16'd0, 1'b1, 1'b0});
      send_tick({ACTION_TICK, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b1});
      send_tick({ACTION_TICK, 32'd0, 16'd1, 1'b1, 1'b1});
      for (k = 1; k <= 5; k++) send_tick({ACTION_TICK, 32'(10 * k), 16'd0, 1'b1, 1'b1});
      req_valid <= 1'b0;
      wait_drained();

      // Directed: zero columns and frames, negative frames, clip kept after finish
      apply_settings(12'd0, 12'd0, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd2, 12'd2);
      send_tick({ACTION_RESTART, 32'd0, 16'd0, 1'b1, 1'b1});
      for (k = 0; k < 6; k++) send_tick({ACTION_TICK, 32'(k), 16'd0, 1'b1, 1'b1});
      req_valid <= 1'b0;

      // Random phases, each with its own settings and idling pattern
      for (p = 0; p < 12; p++) begin
         wait_drained();
         steady_forward = 1'b0;
         if (p == 3) begin
            apply_settings(12'd0, 12'd1, 12'd4095, 12'd4095, 12'd4095, 12'd4095,
                           12'd255, 12'd3);
         end else if (p == 7) begin
            apply_settings(12'd2047, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0);
         end else begin
            pick_settings();
         end
         steady_forward = (p == 3) || (p == 7);
         n = steady_forward ? 300 : 70;
         case (p % 4)
            0: begin
               send_idle_pct = 0;
               stall_pct     = 0;
            end
            1: begin
               send_idle_pct = 63;
               stall_pct     = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct     = 63;
            end
            default: begin
               send_idle_pct = 10;
               stall_pct     = 10;
            end
         endcase
         reverse_pct = (p % 3 == 0) ? 10 : (p % 3 == 1) ? 50 : 90;
         sim_ms      = $urandom();
         if (steady_forward) send_tick({ACTION_RESTART, 32'd0, 16'd0, 1'b0, 1'b1});
         // long hold-off on the result side so the block backs up into its input
         if (p == 4) hold_left = 400;
         for (k = 0; k < n; k++) send_tick(random_tick());
         req_valid <= 1'b0;
      end

      wait_drained();
      repeat (40) @(posedge clock);

      $display("Sent %0d items (%0d restarts) across 14 register settings; %0d clips compared.",
               clips.ticks, clips.restarts, clips.checked);
      $display("Frame steps taken: %0d, animations finished: %0d, mismatches: %0d.",
               clips.steps, clips.finishes, clips.errors);
      if (clips.errors == 0 && clips.expected_clips.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/ssfs_pkg.sv
rtl/sprite_sheet_frame_sequencer_core.sv
test/sprite_sheet_frame_sequencer_core_tb.sv
